@@ src/edf_pkg.sv @@
// Shared types and constants for the EDF task scheduler.
package edf_pkg;

  localparam int TASK_SLOTS    = 8;
  localparam int SLOT_BITS     = $clog2(TASK_SLOTS);
  localparam int TIME_BITS     = 32;
  localparam int ACT_BITS      = 4;
  localparam int WORK_BITS     = 16;
  localparam int OUT_TIME_BITS = 32;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [2:0]  task_slot;
    logic [15:0] capacity;
    logic [15:0] period;
    logic [15:0] relative_deadline;
  } edf_in_t;

  typedef struct packed {
    logic [31:0] tick_time;
    logic        busy_res;
    logic [2:0]  chosen_task;
  } edf_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FINISH
  } edf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_item;
    logic load;
    logic scan_step;
    logic finish;
    logic cfg_we;
  } edf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_tick;
    logic scan_last;
  } edf_status_t;

endpackage

@@ src/edf_ctrl.sv @@
// Sequencer for the EDF scheduler: handshakes, load and scan phases.
module edf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  output edf_pkg::edf_cmd_t   cmd,
  input  edf_pkg::edf_status_t status
);
  import edf_pkg::*;

  edf_state_t state, state_next;
  logic       out_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    cfg_ready      = 1'b1;
    cmd.cfg_we     = cfg_valid;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next    = status.in_is_tick ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/edf_datapath.sv @@
// Task tables, job state, shared release/select unit and result register.
module edf_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  edf_pkg::edf_in_t     in_data,
  input  logic [3:0]           cfg_data,
  input  edf_pkg::edf_cmd_t    cmd,
  output edf_pkg::edf_status_t status,
  output edf_pkg::edf_out_t    out_data
);
  import edf_pkg::*;

  // Task tables and job state, one entry per slot
  logic [WORK_BITS-1:0] cap_tab [TASK_SLOTS];
  logic [WORK_BITS-1:0] per_tab [TASK_SLOTS];
  logic [WORK_BITS-1:0] off_tab [TASK_SLOTS];
  logic [WORK_BITS-1:0] rem     [TASK_SLOTS];
  logic [TIME_BITS-1:0] dl      [TASK_SLOTS];
  logic [WORK_BITS-1:0] cd      [TASK_SLOTS];

  logic [TIME_BITS-1:0] cur_time;
  logic [ACT_BITS-1:0]  active_tasks;
  edf_in_t              item;
  logic [SLOT_BITS-1:0] idx;
  logic                 found;
  logic [TIME_BITS-1:0] best_key;
  logic [WORK_BITS-1:0] best_rem;
  logic [SLOT_BITS-1:0] pick;

  // Current slot under scan
  logic                 slot_on, counting, release_job, take;
  logic [WORK_BITS-1:0] cap_i, per_i, off_i, rem_i, cd_i;
  logic [TIME_BITS-1:0] dl_i;
  logic [WORK_BITS-1:0] rem_new, cd_new;
  logic [TIME_BITS-1:0] dl_new, diff, key;

  assign status.in_is_tick = (in_data.action == ACTION_TICK);
  assign status.scan_last  = (idx == SLOT_BITS'(TASK_SLOTS - 1));

  // Release, countdown and earliest-deadline compare for one slot
  always_comb begin
    cap_i = cap_tab[idx];
    per_i = per_tab[idx];
    off_i = off_tab[idx];
    rem_i = rem[idx];
    dl_i  = dl[idx];
    cd_i  = cd[idx];

    slot_on     = ({1'b0, idx} < active_tasks);
    counting    = slot_on && (per_i != '0);
    release_job = counting && (cd_i == '0);

    rem_new = release_job ? cap_i : rem_i;
    dl_new  = release_job ? (cur_time + TIME_BITS'(off_i)) : dl_i;
    if (!counting) begin
      cd_new = cd_i;
    end else if (release_job) begin
      cd_new = per_i - 1'b1;
    end else begin
      cd_new = cd_i - 1'b1;
    end

    // deadline minus time, offset by half range so unsigned order is signed order
    diff = release_job ? TIME_BITS'(off_i) : (dl_i - cur_time);
    key  = {~diff[TIME_BITS-1], diff[TIME_BITS-2:0]};
    take = slot_on && (rem_new != '0) && (!found || (key < best_key));
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_tasks <= ACT_BITS'(1);
    end else if (cmd.cfg_we) begin
      active_tasks <= cfg_data;
    end
  end

  // Accepted item
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item <= in_data;
    end
  end

  // Scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
      pick  <= '0;
    end else if (cmd.take_item) begin
      idx   <= '0;
      found <= 1'b0;
      pick  <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
      if (take) begin
        found <= 1'b1;
        pick  <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && take) begin
      best_key <= key;
      best_rem <= rem_new;
    end
  end

  // Tables, job state and time
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        cap_tab[i] <= '0;
        per_tab[i] <= '0;
        off_tab[i] <= '0;
        rem[i]     <= '0;
        dl[i]      <= '0;
        cd[i]      <= '0;
      end
    end else if (cmd.load) begin
      cap_tab[item.task_slot] <= item.capacity;
      per_tab[item.task_slot] <= item.period;
      off_tab[item.task_slot] <= item.relative_deadline;
      cur_time <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        rem[i] <= '0;
        dl[i]  <= '0;
        cd[i]  <= '0;
      end
    end else if (cmd.scan_step) begin
      rem[idx] <= rem_new;
      dl[idx]  <= dl_new;
      cd[idx]  <= cd_new;
    end else if (cmd.finish) begin
      if (found) begin
        rem[pick] <= best_rem - 1'b1;
      end
      cur_time <= cur_time + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.tick_time   <= cur_time[OUT_TIME_BITS-1:0];
      out_data.busy_res    <= found;
      out_data.chosen_task <= found ? 3'(pick) : 3'd0;
    end
  end

endmodule

@@ src/edf_task_scheduler.sv @@
// Top level of the earliest-deadline-first periodic task scheduler.
//
// Input channel (in_valid/in_ready/in_data): one beat is either a load
// (action 0), which writes one slot's capacity, period and relative
// deadline and restarts the schedule, or a tick (action 1), which releases
// due jobs, runs the ready job with the earliest deadline for one tick and
// returns one result beat on out_valid/out_ready/out_data.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes active_tasks; it
// is always ready and is meant to be written while the block is idle.
// Flow: a load holds in_ready low in the cycle after acceptance, while
// the slot is written; no new beat is accepted until the block is idle.
// A tick visits the 8 task slots one per cycle through a single
// release/compare unit, then updates the chosen job's work and the time
// in a finish step that loads the result register.
// The output is registered: if the receiver stalls, the finished result
// holds and the next tick waits in its finish step until the result is
// taken. Reset clears all tables, job state and time, sets active_tasks to
// 1, and the block is ready on the next cycle.
module edf_task_scheduler (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  edf_pkg::edf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output edf_pkg::edf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data
);
  import edf_pkg::*;

  edf_cmd_t    cmd;
  edf_status_t status;

  edf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .status    (status)
  );

  edf_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

@@ tb/sv/edf_task_scheduler_tb.sv @@
// Self-checking testbench for the EDF task scheduler: directed and random beats.
module edf_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  edf_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  edf_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [3:0] cfg_data;

  // Shadow scheduler state
  logic [ACT_BITS-1:0]  active_cfg = 4'd1;
  logic [WORK_BITS-1:0] cap_tbl[TASK_SLOTS] = '{default: '0};
  logic [WORK_BITS-1:0] per_tbl[TASK_SLOTS] = '{default: '0};
  logic [WORK_BITS-1:0] rel_dl_tbl[TASK_SLOTS] = '{default: '0};
  logic [WORK_BITS-1:0] work_left[TASK_SLOTS] = '{default: '0};
  logic [TIME_BITS-1:0] abs_dl[TASK_SLOTS] = '{default: '0};
  logic [WORK_BITS-1:0] countdown[TASK_SLOTS] = '{default: '0};
  logic [TIME_BITS-1:0] sched_time = '0;

  edf_out_t pending_picks[$];

  int fail_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  edf_task_scheduler dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Print one mismatch line and count it
  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Apply one accepted beat to the shadow state; ticks queue the expected pick
  function automatic void apply_sched_item(edf_in_t it);
    int n;
    int pick;
    logic signed [TIME_BITS-1:0] best;
    logic signed [TIME_BITS-1:0] key;
    edf_out_t res;
    if (it.action == ACTION_LOAD) begin
      cap_tbl[it.task_slot] = it.capacity;
      per_tbl[it.task_slot] = it.period;
      rel_dl_tbl[it.task_slot] = it.relative_deadline;
      sched_time = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        work_left[i] = '0;
        abs_dl[i] = '0;
        countdown[i] = '0;
      end
      return;
    end
    n = (active_cfg > TASK_SLOTS) ? TASK_SLOTS : int'(active_cfg);
    // release due jobs, count down the rest
    for (int i = 0; i < n; i++) begin
      if (per_tbl[i] != 0) begin
        if (countdown[i] == 0) begin
          work_left[i] = cap_tbl[i];
          abs_dl[i] = sched_time + TIME_BITS'(rel_dl_tbl[i]);
          countdown[i] = per_tbl[i] - 1'b1;
        end else begin
          countdown[i] = countdown[i] - 1'b1;
        end
      end
    end
    // earliest deadline among ready jobs, lowest slot on ties
    pick = -1;
    best = '0;
    for (int i = 0; i < n; i++) begin
      if (work_left[i] != 0) begin
        key = $signed(abs_dl[i] - sched_time);
        if (pick < 0 || key < best) begin
          pick = i;
          best = key;
        end
      end
    end
    res.tick_time = sched_time;
    res.busy_res = (pick >= 0);
    res.chosen_task = (pick >= 0) ? 3'(pick) : 3'd0;
    if (pick >= 0) work_left[pick] = work_left[pick] - 1'b1;
    sched_time = sched_time + 1'b1;
    pending_picks.push_back(res);
  endfunction

  // Beat monitor: checks results, tracks accepted inputs and config, watchdog
  always @(posedge clk) begin
    edf_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_picks.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat %p", out_data));
        end else begin
          want = pending_picks.pop_front();
          if (out_data.tick_time !== want.tick_time)
            flag_mismatch($sformatf("tick_time got %0d want %0d",
                                    out_data.tick_time, want.tick_time));
          if (out_data.busy_res !== want.busy_res)
            flag_mismatch($sformatf("busy_res got %0b want %0b at time %0d",
                                    out_data.busy_res, want.busy_res, want.tick_time));
          if (out_data.chosen_task !== want.chosen_task)
            flag_mismatch($sformatf("chosen_task got %0d want %0d at time %0d",
                                    out_data.chosen_task, want.chosen_task,
                                    want.tick_time));
        end
      end
      if (in_valid && in_ready) apply_sched_item(in_data);
      if (cfg_valid && cfg_ready) active_cfg = cfg_data;
    end
  end

  // Receiver: random backpressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one beat on the input channel, with random idle cycles ahead of it
  task automatic send_item(edf_in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop sending and wait until every queued pick has come back
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_active(logic [3:0] value);
    wait_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic edf_in_t load_item(int slot, int cap, int per, int dl);
    edf_in_t it;
    it.action = ACTION_LOAD;
    it.task_slot = 3'(slot);
    it.capacity = 16'(cap);
    it.period = 16'(per);
    it.relative_deadline = 16'(dl);
    return it;
  endfunction

  // Tick beat; the unused fields carry random junk
  function automatic edf_in_t tick_item();
    edf_in_t it;
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    it = junk[$bits(edf_in_t)-1:0];
    it.action = ACTION_TICK;
    return it;
  endfunction

  // Random load: mostly small values; sometimes full-range
  function automatic edf_in_t random_load(int slot, bit wild);
    if (wild || $urandom_range(99) < 10)
      return load_item($urandom_range(7), $urandom_range(65535),
                       $urandom_range(65535), $urandom_range(65535));
    return load_item(slot, $urandom_range(5),
                     ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 12),
                     $urandom_range(15));
  endfunction

  // Ticks straight after reset: only slot 0 active, nothing loaded
  task automatic test_reset_state();
    send_item(tick_item());
    send_item(tick_item());
  endtask

  // All-ones and all-zeros field values
  task automatic test_field_extremes();
    send_item(load_item(0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(load_item(7, 0, 0, 0));
    send_item(tick_item());
    send_item(tick_item());
  endtask

  // Saturated, zero and full active counts; ties and overwritten jobs
  task automatic test_active_count();
    write_active(4'd15);
    send_item(load_item(1, 2, 3, 2));
    send_item(load_item(2, 1, 1, 2));
    send_item(load_item(3, 5, 2, 1));
    repeat (5) send_item(tick_item());
    write_active(4'd0);
    repeat (2) send_item(tick_item());
    write_active(4'd8);
    repeat (2) send_item(tick_item());
  endtask

  // One task set: loads followed by a run of ticks, sometimes a stray load
  task automatic run_task_set();
    int n_load;
    int n_tick;
    n_load = $urandom_range(1, 8);
    for (int s = 0; s < n_load; s++) send_item(random_load(s, 1'b0));
    n_tick = $urandom_range(8, 40);
    repeat (n_tick) begin
      if ($urandom_range(99) < 4) send_item(random_load(0, 1'b1));
      else send_item(tick_item());
    end
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, int count);
    int goal;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(3) == 0) write_active(4'(8 + $urandom_range(1) * 7));
        else write_active(4'($urandom_range(15)));
      end
      run_task_set();
    end
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 31;
    recv_stall_pct = 79;
    test_reset_state();
    test_field_extremes();
    test_active_count();
    write_active(4'd1);
    test_random_phase(31, 79, 340);
    test_random_phase(79, 31, 340);
    test_random_phase(0, 0, 340);

    wait_drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
